>>> sv/abfm_pkg.sv
// Shared types and constants for the adaptive byte frequency model.
package abfm_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int CNT_W            = 14;
    localparam int TOT_W            = 15;
    localparam int ACC_W            = 16;
    localparam int TOTAL_LIMIT      = 16384;

    typedef enum logic [1:0] {
        CMD_ENC = 2'd0,
        CMD_DEC = 2'd1,
        CMD_RAW = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_UPD,
        ST_RESC,
        ST_RESC_END,
        ST_RESC_FIN,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic [13:0] low;
        logic [13:0] freq;
        logic [13:0] total;
        logic [7:0]  sym;
        logic        need_raw;
        logic        last;
    } res_t;

    typedef struct packed {
        logic load_in;
        logic load_esc;
        logic idx_clr;
        logic idx_inc;
        logic clr_wr;
        logic scan_rd;
        logic upd;
        logic resc_rd;
        logic resc_fin;
        logic send_adv;
    } ctrl_t;

    typedef struct packed {
        cmd_t in_cmd;
        logic in_tgt_zero;
        logic idx_last;
        logic need_resc;
        logic more_res;
    } stat_t;

endpackage

>>> sv/abfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module abfm_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/abfm_ctrl.sv
// Controller state machine sequencing clear, scan, update, rescale and send.
module abfm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  abfm_pkg::stat_t stat,
    output abfm_pkg::ctrl_t ctrl
);

    abfm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= abfm_pkg::ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            abfm_pkg::ST_CLR: begin
                ctrl.clr_wr  = 1'b1;
                ctrl.idx_inc = 1'b1;
                if (stat.idx_last) begin
                    ctrl.idx_clr = 1'b1;
                    state_next   = abfm_pkg::ST_IDLE;
                end
            end
            abfm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (stat.in_cmd == abfm_pkg::CMD_NOP) begin
                        state_next = abfm_pkg::ST_IDLE;
                    end else if (stat.in_cmd == abfm_pkg::CMD_DEC && stat.in_tgt_zero) begin
                        ctrl.load_esc = 1'b1;
                        state_next    = abfm_pkg::ST_SEND;
                    end else begin
                        ctrl.load_in = 1'b1;
                        ctrl.idx_clr = 1'b1;
                        state_next   = abfm_pkg::ST_SCAN;
                    end
                end
            end
            abfm_pkg::ST_SCAN: begin
                ctrl.scan_rd = 1'b1;
                ctrl.idx_inc = 1'b1;
                if (stat.idx_last) begin
                    ctrl.idx_clr = 1'b1;
                    state_next   = abfm_pkg::ST_SCAN_END;
                end
            end
            abfm_pkg::ST_SCAN_END: begin
                state_next = abfm_pkg::ST_UPD;
            end
            abfm_pkg::ST_UPD: begin
                ctrl.upd   = 1'b1;
                state_next = stat.need_resc ? abfm_pkg::ST_RESC : abfm_pkg::ST_SEND;
            end
            abfm_pkg::ST_RESC: begin
                ctrl.resc_rd = 1'b1;
                ctrl.idx_inc = 1'b1;
                if (stat.idx_last) begin
                    ctrl.idx_clr = 1'b1;
                    state_next   = abfm_pkg::ST_RESC_END;
                end
            end
            abfm_pkg::ST_RESC_END: begin
                state_next = abfm_pkg::ST_RESC_FIN;
            end
            abfm_pkg::ST_RESC_FIN: begin
                ctrl.resc_fin = 1'b1;
                state_next    = abfm_pkg::ST_SEND;
            end
            abfm_pkg::ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    ctrl.send_adv = 1'b1;
                    if (!stat.more_res) begin
                        state_next = abfm_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = abfm_pkg::ST_CLR;
            end
        endcase
    end

endmodule

>>> sv/abfm_dp.sv
// Datapath: count memory, scan accumulator, totals and result registers.
module abfm_dp #(
    parameter int SYMBOL_COUNT = abfm_pkg::SYMBOL_COUNT_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      in_cmd,
    input  logic [7:0]      in_symbol,
    input  logic [13:0]     in_target,
    input  logic            cfg_wr_en,
    input  logic [14:0]     cfg_wr_data,
    input  abfm_pkg::ctrl_t ctrl,
    output abfm_pkg::stat_t stat,
    output abfm_pkg::res_t  res_out
);

    localparam int IW = $clog2(SYMBOL_COUNT);
    localparam logic [IW-1:0] LAST_IDX = IW'(SYMBOL_COUNT - 1);
    localparam int CW = abfm_pkg::CNT_W;
    localparam int TW = abfm_pkg::TOT_W;
    localparam int AW = abfm_pkg::ACC_W;

    logic [TW-1:0] thr_reg;
    logic [TW-1:0] total_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] ridx_reg;
    logic          scan_v_reg;
    logic          resc_v_reg;
    logic          found_reg;
    logic [AW-1:0] acc_reg;
    logic [AW-1:0] low_reg;
    logic [CW-1:0] freq_reg;
    logic [IW-1:0] sel_reg;
    abfm_pkg::cmd_t cmd_reg;
    logic [IW-1:0] sym_reg;
    logic [13:0]   tgt_reg;
    abfm_pkg::res_t res0_reg, res1_reg;
    logic          two_reg;
    logic          out_sel_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [CW-1:0] ram_rdata;
    logic [CW-1:0] half;
    logic [AW-1:0] acc_plus;
    logic          hit;
    logic [TW-1:0] thr_eff;
    logic [TW-1:0] total_inc;
    logic [IW-1:0] sym_clamp;

    abfm_ram #(.WIDTH(CW), .DEPTH(SYMBOL_COUNT)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign sym_clamp = (32'(in_symbol) >= SYMBOL_COUNT) ? LAST_IDX : IW'(in_symbol);
    assign half      = CW'(({1'b0, ram_rdata} + 1'b1) >> 1);
    assign acc_plus  = acc_reg + AW'(ram_rdata);
    assign thr_eff   = (thr_reg > TW'(abfm_pkg::TOTAL_LIMIT)) ?
                       TW'(abfm_pkg::TOTAL_LIMIT) : thr_reg;
    assign total_inc = total_reg + 1'b1;

    always_comb begin
        if (cmd_reg == abfm_pkg::CMD_DEC) begin
            hit = ({1'b0, tgt_reg} < total_reg) &&
                  ((AW'(tgt_reg) - 1'b1) < acc_plus);
        end else begin
            hit = (ridx_reg == sym_reg);
        end
        hit = !found_reg && (hit || ridx_reg == LAST_IDX);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        if (ctrl.clr_wr) begin
            ram_we = 1'b1;
        end else if (ctrl.upd) begin
            ram_we    = 1'b1;
            ram_waddr = sel_reg;
            ram_wdata = freq_reg + 1'b1;
        end else if (resc_v_reg) begin
            ram_we    = 1'b1;
            ram_waddr = ridx_reg;
            ram_wdata = half;
        end
    end

    always_comb begin
        stat.in_cmd      = abfm_pkg::cmd_t'(in_cmd);
        stat.in_tgt_zero = (in_target == '0);
        stat.idx_last    = (idx_reg == LAST_IDX);
        stat.need_resc   = (total_inc >= thr_eff);
        stat.more_res    = two_reg && !out_sel_reg;
        res_out          = out_sel_reg ? res1_reg : res0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= TW'(abfm_pkg::TOTAL_LIMIT);
            total_reg   <= TW'(1);
            idx_reg     <= '0;
            scan_v_reg  <= 1'b0;
            resc_v_reg  <= 1'b0;
            found_reg   <= 1'b0;
            two_reg     <= 1'b0;
            out_sel_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (ctrl.idx_clr) begin
                idx_reg <= '0;
            end else if (ctrl.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            scan_v_reg <= ctrl.scan_rd;
            resc_v_reg <= ctrl.resc_rd;
            if (ctrl.load_in) begin
                found_reg <= 1'b0;
            end else if (scan_v_reg && hit) begin
                found_reg <= 1'b1;
            end
            if (ctrl.upd) begin
                total_reg <= total_inc;
            end else if (ctrl.resc_fin) begin
                total_reg <= TW'(acc_reg + 1'b1);
            end
            if (ctrl.load_in || ctrl.load_esc) begin
                out_sel_reg <= 1'b0;
                two_reg     <= 1'b0;
            end else if (ctrl.upd) begin
                two_reg <= (cmd_reg == abfm_pkg::CMD_ENC) && (freq_reg == '0);
            end else if (ctrl.send_adv) begin
                out_sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg <= idx_reg;
        if (ctrl.load_in) begin
            cmd_reg <= abfm_pkg::cmd_t'(in_cmd);
            sym_reg <= sym_clamp;
            tgt_reg <= in_target;
        end
        if (ctrl.load_in || ctrl.upd) begin
            acc_reg <= '0;
        end else if (scan_v_reg) begin
            acc_reg <= acc_plus;
        end else if (resc_v_reg) begin
            acc_reg <= acc_reg + AW'(half);
        end
        if (scan_v_reg && hit) begin
            low_reg  <= acc_reg;
            freq_reg <= ram_rdata;
            sel_reg  <= ridx_reg;
        end
        if (ctrl.load_esc) begin
            res0_reg <= '{low: '0, freq: 14'd1, total: 14'(total_reg), sym: '0,
                          need_raw: 1'b1, last: 1'b1};
        end else if (ctrl.upd) begin
            unique case (cmd_reg)
                abfm_pkg::CMD_ENC: begin
                    if (freq_reg != '0) begin
                        res0_reg <= '{low: 14'(low_reg + 1'b1), freq: freq_reg,
                                      total: 14'(total_reg), sym: '0,
                                      need_raw: 1'b0, last: 1'b1};
                    end else begin
                        res0_reg <= '{low: '0, freq: 14'd1, total: 14'(total_reg),
                                      sym: '0, need_raw: 1'b0, last: 1'b0};
                    end
                end
                abfm_pkg::CMD_DEC: begin
                    res0_reg <= '{low: 14'(low_reg + 1'b1), freq: freq_reg,
                                  total: 14'(total_reg), sym: 8'(sel_reg),
                                  need_raw: 1'b0, last: 1'b1};
                end
                default: begin
                    res0_reg <= '{low: 14'(sym_reg), freq: 14'd1,
                                  total: 14'(SYMBOL_COUNT), sym: 8'(sym_reg),
                                  need_raw: 1'b0, last: 1'b1};
                end
            endcase
            res1_reg <= '{low: 14'(sym_reg), freq: 14'd1, total: 14'(SYMBOL_COUNT),
                          sym: '0, need_raw: 1'b0, last: 1'b1};
        end
    end

endmodule

>>> sv/adaptive_byte_freq_model.sv
// Top level of the adaptive order-0 frequency model for an arithmetic coder.
//
// The input channel takes one item per command: s_tuser carries the command
// (encode, decode target, raw symbol after escape), s_tdata the symbol and
// the decode target. The result channel returns the coded range, the decoded
// symbol, the escape flag on m_tuser and m_tlast on the final result of an item.
// An encode of an unseen symbol returns two results; other commands return
// one, and the unused command code returns none.
// Each item is handled one at a time. The count memory is swept once per item
// to form the cumulative sum or to find the decoded symbol before its first
// result is offered; a decode with a zero target answers without a sweep.
// When the total reaches the rescale threshold, a second sweep halves every
// count. The count memory has a single read port, so each sweep reads its
// entries one after another.
// After reset the block clears the count memory, one entry a cycle, and accepts
// no item meanwhile; the threshold register can be written at any time the
// block is idle. If the receiver stalls, the result is held stable on m_tdata
// and the block takes no new item until all results of the current item have
// been taken.
module adaptive_byte_freq_model #(
    parameter int SYMBOL_COUNT = abfm_pkg::SYMBOL_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,   // rescale_threshold
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // symbol[7:0], target[21:8], zero pad
    input  logic [1:0]  s_tuser,       // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,       // range_low, range_freq, range_total,
                                       // decoded_symbol, zero pad
    output logic [0:0]  m_tuser,       // need_raw
    output logic        m_tlast
);

    abfm_pkg::ctrl_t ctrl;
    abfm_pkg::stat_t stat;
    abfm_pkg::res_t  res;

    // The controller only sequences; all count and result storage lives in the datapath.
    abfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    abfm_dp #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_cmd      (s_tuser),
        .in_symbol   (s_tdata[7:0]),
        .in_target   (s_tdata[21:8]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctrl        (ctrl),
        .stat        (stat),
        .res_out     (res)
    );

    // Results are packed from the low bits up with the pad bits held at zero.
    assign m_tdata = {6'b0, res.sym, res.total, res.freq, res.low};
    assign m_tuser = res.need_raw;
    assign m_tlast = res.last;

endmodule
